FILE: sv/sc1_pkg.sv
// Shared types, command codes and translation tables for the set 1 scancode decoder.
// No dependencies.
package sc1_pkg;

   localparam logic [1:0] CMD_SCAN  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [7:0] SC_PREFIX  = 8'hE0;
   localparam logic [6:0] SC_LSHIFT  = 7'h2A;
   localparam logic [6:0] SC_RSHIFT  = 7'h36;
   localparam logic [6:0] SC_F4      = 7'h3E;
   localparam logic [6:0] CH_F4      = 7'h0F;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] scan_byte;
      logic [7:0] key_index;
   } req_word_type;

   typedef struct packed {
      logic       char_valid;
      logic [6:0] char_code;
      logic       key_is_down;
      logic [5:0] chars_buffered;
   } rsp_word_type;

   // unshifted ASCII for normal key codes
   function automatic logic [6:0] plain_char(input logic [6:0] code);
      logic [6:0] ch;
      unique case (code)
         7'h01: ch = 7'h1B;  7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
         7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;
         7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;  7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;
         7'h0D: ch = 7'h3D;  7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;  7'h10: ch = 7'h71;
         7'h11: ch = 7'h77;  7'h12: ch = 7'h65;  7'h13: ch = 7'h72;  7'h14: ch = 7'h74;
         7'h15: ch = 7'h79;  7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
         7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;  7'h1C: ch = 7'h0A;
         7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;  7'h21: ch = 7'h66;
         7'h22: ch = 7'h67;  7'h23: ch = 7'h68;  7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;
         7'h26: ch = 7'h6C;  7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h29: ch = 7'h60;
         7'h2B: ch = 7'h5C;  7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;
         7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;  7'h32: ch = 7'h6D;
         7'h33: ch = 7'h2C;  7'h34: ch = 7'h2E;  7'h35: ch = 7'h2F;  7'h37: ch = 7'h2A;
         7'h39: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // shifted ASCII for normal key codes
   function automatic logic [6:0] shift_char(input logic [6:0] code);
      logic [6:0] ch;
      unique case (code)
         7'h01: ch = 7'h1B;  7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;
         7'h05: ch = 7'h24;  7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;  7'h08: ch = 7'h26;
         7'h09: ch = 7'h2A;  7'h0A: ch = 7'h28;  7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;
         7'h0D: ch = 7'h2B;  7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;  7'h10: ch = 7'h51;
         7'h11: ch = 7'h57;  7'h12: ch = 7'h45;  7'h13: ch = 7'h52;  7'h14: ch = 7'h54;
         7'h15: ch = 7'h59;  7'h16: ch = 7'h55;  7'h17: ch = 7'h49;  7'h18: ch = 7'h4F;
         7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;  7'h1C: ch = 7'h0A;
         7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;  7'h21: ch = 7'h46;
         7'h22: ch = 7'h47;  7'h23: ch = 7'h48;  7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;
         7'h26: ch = 7'h4C;  7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;  7'h29: ch = 7'h7E;
         7'h2B: ch = 7'h7C;  7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;
         7'h2F: ch = 7'h56;  7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;  7'h32: ch = 7'h4D;
         7'h33: ch = 7'h3C;  7'h34: ch = 7'h3E;  7'h35: ch = 7'h3F;  7'h37: ch = 7'h2A;
         7'h39: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // control codes for extended keys (arrows, home/end, paging, delete)
   function automatic logic [6:0] ext_char(input logic [6:0] code);
      logic [6:0] ch;
      unique case (code)
         7'h48: ch = 7'h01;  // up
         7'h50: ch = 7'h02;  // down
         7'h4B: ch = 7'h03;  // left
         7'h4D: ch = 7'h04;  // right
         7'h53: ch = 7'h7F;  // delete
         7'h47: ch = 7'h05;  // home
         7'h4F: ch = 7'h06;  // end
         7'h49: ch = 7'h0B;  // page up
         7'h51: ch = 7'h0C;  // page down
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/scancode_set1_to_ascii_decoder.sv
// A word accepted on req_valid && req_ready is registered into the output stage, whose
// rsp_valid/rsp_word are taken on rsp_ready. Throughput 1 word per cycle unless rsp_ready
// stalls the output; each word reads the key memory and the FIFO once, and a scan word may
// also write each. The key RAM and FIFO RAM reads are registered and form the output stage.
// Synchronous active-high reset clears key valid bits, shift mirrors, prefix flag, pointers
// and the output valid; RAM contents are not cleared (key entries read as released until
// written).
//
// Top level of the set 1 scancode decoder. Depends on sc1_pkg.
module scancode_set1_to_ascii_decoder #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sc1_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sc1_pkg::rsp_word_type rsp_word
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW    = PTR_W + 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CW-1:0]    DEPTH_CW = CW'(FIFO_DEPTH);

   // ---------------- storage ----------------
   logic       key_mem  [256];          // held bit per key, {extended, code}
   logic [6:0] fifo_mem [FIFO_DEPTH];   // character ring
   logic [255:0] key_vld_ff, key_vld_in; // entry written since reset

   logic             ext_ff, ext_in;     // 0xE0 seen, next code is extended
   logic             lshift_ff, lshift_in;
   logic             rshift_ff, rshift_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;

   // output stage
   logic             s2_valid_ff, s2_valid_in;
   logic             pop_hit_ff;
   logic             query_ff;
   logic             kvld_rd_ff;
   logic             key_rd_ff;
   logic [6:0]       fifo_rd_ff;
   logic [PTR_W-1:0] count_ff;

   // ---------------- stage 1 decode ----------------
   logic             accept;
   logic             is_scan, is_pop, is_query;
   logic             is_prefix, is_release;
   logic [6:0]       code;
   logic [7:0]       key_addr;
   logic             key_we;
   logic [6:0]       ch;
   logic             fifo_we;
   logic             pop_hit;
   logic [PTR_W-1:0] wp_nxt, rp_nxt;
   logic [CW-1:0]    diff;
   logic [PTR_W-1:0] count_in;
   logic [CW+5:0]    count_wide;

   // next stage frees when empty or when its word is taken this cycle
   assign req_ready = !s2_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_scan  = (req_word.command == sc1_pkg::CMD_SCAN);
   assign is_pop   = (req_word.command == sc1_pkg::CMD_POP);
   assign is_query = (req_word.command == sc1_pkg::CMD_QUERY);

   assign is_prefix  = (req_word.scan_byte == sc1_pkg::SC_PREFIX);
   assign is_release = req_word.scan_byte[7];
   assign code       = req_word.scan_byte[6:0];
   assign key_addr   = {ext_ff, code};
   assign key_we     = accept && is_scan && !is_prefix;

   assign wp_nxt = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
   assign rp_nxt = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;

   // Translation. Shift mirrors hold the state before this byte; a shift press itself
   // maps to zero in both tables, so the ordering does not matter.
   always_comb begin
      if (ext_ff) begin
         ch = sc1_pkg::ext_char(code);
      end else if (code == sc1_pkg::SC_F4) begin
         ch = sc1_pkg::CH_F4;
      end else if (lshift_ff || rshift_ff) begin
         ch = sc1_pkg::shift_char(code);
      end else begin
         ch = sc1_pkg::plain_char(code);
      end
   end

   // drop when full: ring keeps one slot empty
   assign fifo_we = key_we && !is_release && (ch != 7'd0) && (wp_nxt != rp_ff);
   assign pop_hit = accept && is_pop && (rp_ff != wp_ff);

   always_comb begin
      ext_in     = ext_ff;
      lshift_in  = lshift_ff;
      rshift_in  = rshift_ff;
      key_vld_in = key_vld_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      if (accept && is_scan) begin
         ext_in = is_prefix;
      end
      if (key_we) begin
         key_vld_in[key_addr] = 1'b1;
         if (!ext_ff && code == sc1_pkg::SC_LSHIFT) begin
            lshift_in = !is_release;
         end
         if (!ext_ff && code == sc1_pkg::SC_RSHIFT) begin
            rshift_in = !is_release;
         end
      end
      if (fifo_we) begin
         wp_in = wp_nxt;
      end
      if (pop_hit) begin
         rp_in = rp_nxt;
      end
   end

   // occupancy after this word, modulo depth
   always_comb begin
      diff = {1'b0, wp_in} - {1'b0, rp_in};
      if (wp_in < rp_in) begin
         diff = diff + DEPTH_CW;
      end
      count_in = diff[PTR_W-1:0];
   end

   assign s2_valid_in = accept || (s2_valid_ff && !rsp_ready);

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_addr] <= !is_release;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[wp_ff] <= ch;
      end
   end

   // registered reads, held while the output is stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         key_rd_ff  <= key_mem[req_word.key_index];
         kvld_rd_ff <= key_vld_ff[req_word.key_index];
         fifo_rd_ff <= fifo_mem[rp_ff];
         pop_hit_ff <= pop_hit;
         query_ff   <= is_query;
         count_ff   <= count_in;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff  <= '0;
         ext_ff      <= 1'b0;
         lshift_ff   <= 1'b0;
         rshift_ff   <= 1'b0;
         wp_ff       <= '0;
         rp_ff       <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         key_vld_ff  <= key_vld_in;
         ext_ff      <= ext_in;
         lshift_ff   <= lshift_in;
         rshift_ff   <= rshift_in;
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // ---------------- response ----------------
   assign count_wide = (CW+6)'(count_ff);

   assign rsp_valid                = s2_valid_ff;
   assign rsp_word.char_valid      = pop_hit_ff;
   assign rsp_word.char_code       = pop_hit_ff ? fifo_rd_ff : 7'd0;
   assign rsp_word.key_is_down     = query_ff && kvld_rd_ff && key_rd_ff;
   assign rsp_word.chars_buffered  = count_wide[5:0];

endmodule
